### hw/rtl/tgs_pkg.sv
// Shared constants, types and codes for the turmite grid stepper.
`default_nettype none

package tgs_pkg;

  localparam int GRID_SIZE  = 128;
  localparam int MAX_RULES  = 16;
  localparam int COLOR_BITS = 4;

  localparam int POS_W      = $clog2(GRID_SIZE);
  localparam int CELLS      = GRID_SIZE * GRID_SIZE;
  localparam int CELL_AW    = $clog2(CELLS);
  localparam int RULE_IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int RULE_CNT_W = $clog2(MAX_RULES + 1);
  localparam int STATE_W    = 4;
  localparam int LIMIT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [POS_W-1:0]   POS_CENTER = POS_W'(GRID_SIZE / 2);
  localparam logic [POS_W-1:0]   POS_MAX    = POS_W'(GRID_SIZE - 1);
  localparam logic [CELL_AW-1:0] SWEEP_LAST = CELL_AW'(CELLS - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_EN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 2'd3;

  typedef enum logic [1:0] {
    OP_WRITE_RULE = 2'd0,
    OP_STEP       = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_READ_CELL  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_NO_MATCH  = 2'd1,
    STAT_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    HD_ROW_DOWN = 2'd0,
    HD_COL_UP   = 2'd1,
    HD_ROW_UP   = 2'd2,
    HD_COL_DOWN = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    TURN_LEFT     = 2'd0,
    TURN_STRAIGHT = 2'd1,
    TURN_RIGHT    = 2'd2,
    TURN_BACK     = 2'd3
  } turn_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [STATE_W-1:0]    st;
    logic                  st_any;
    logic [COLOR_BITS-1:0] col;
    logic                  col_any;
    logic [COLOR_BITS-1:0] ncol;
    logic                  col_keep;
    turn_t                 turn;
    logic [STATE_W-1:0]    nst;
    logic                  st_keep;
  } rule_t;

  typedef struct packed {
    logic                  we;
    logic [CELL_AW-1:0]    addr;
    logic [COLOR_BITS-1:0] data;
  } grid_wr_t;

endpackage

`default_nettype wire

### hw/rtl/tgs_grid_mem.sv
// Cell colour memory: one write port, one registered read port.
`default_nettype none

module tgs_grid_mem (
  input  wire logic                            clk,
  input  wire tgs_pkg::grid_wr_t               wr,
  input  wire logic                            re,
  input  wire logic [tgs_pkg::CELL_AW-1:0]     raddr,
  output logic      [tgs_pkg::COLOR_BITS-1:0]  rdata
);

  logic [tgs_pkg::COLOR_BITS-1:0] mem [tgs_pkg::CELLS];
  logic [tgs_pkg::COLOR_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/tgs_rule_unit.sv
// Rule table and the shared compare unit that tests one rule per cycle.
`default_nettype none

module tgs_rule_unit (
  input  wire logic                              clk,
  input  wire logic                              wr_en,
  input  wire logic [tgs_pkg::RULE_IDX_W-1:0]    wr_idx,
  input  wire tgs_pkg::rule_t                    wr_rule,
  input  wire logic [tgs_pkg::RULE_IDX_W-1:0]    rd_idx,
  input  wire logic [tgs_pkg::STATE_W-1:0]       cur_state,
  input  wire logic [tgs_pkg::COLOR_BITS-1:0]    cur_color,
  output logic                                   hit,
  output tgs_pkg::rule_t                         rd_rule
);

  tgs_pkg::rule_t rules_r [tgs_pkg::MAX_RULES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rules_r[wr_idx] <= wr_rule;
    end
  end

  assign rd_rule = rules_r[rd_idx];
  assign hit = (rd_rule.st_any || (rd_rule.st == cur_state)) &&
               (rd_rule.col_any || (rd_rule.col == cur_color));

endmodule

`default_nettype wire

### hw/rtl/turmite_grid_stepper.sv
// Turmite engine top level: sequencer, head and budget registers, result register.
//
// One request is taken when start is high and busy is low; its result appears
// on the out_ ports for a single cycle with out_valid and cannot be held off.
// Write rule and read cell go through the cell read and the done state to the
// result strobe. A step reads the head cell, and the single rule compare unit
// tests one rule per cycle from rule 0 between the cell read and the cell write.
// When a rule fires the new head cell is read before the done state; when none
// of the n rules in use matches the scan ends there; an exhausted budget goes
// from the cell read to the done state. Clear sweeps all 16384 cells one per
// cycle, then reads the head cell; the same sweep runs after reset, with busy high.
// Configuration writes are taken at any time but belong while the block is idle.
`default_nettype none

module turmite_grid_stepper (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [tgs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tgs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         in_operation,
  input  wire logic [3:0]                         in_rule_index,
  input  wire logic [3:0]                         in_rule_state,
  input  wire logic                               in_rule_state_any,
  input  wire logic [3:0]                         in_rule_color,
  input  wire logic                               in_rule_color_any,
  input  wire logic [3:0]                         in_rule_new_color,
  input  wire logic                               in_rule_color_keep,
  input  wire logic [1:0]                         in_rule_turn,
  input  wire logic [3:0]                         in_rule_new_state,
  input  wire logic                               in_rule_state_keep,
  input  wire logic [13:0]                        in_cell_address,
  output logic                                    out_valid,
  output logic [1:0]                              out_status,
  output logic [tgs_pkg::POS_W-1:0]               out_pos_row,
  output logic [tgs_pkg::POS_W-1:0]               out_pos_col,
  output logic [1:0]                              out_heading,
  output logic [3:0]                              out_current_state,
  output logic [3:0]                              out_cell_color,
  output logic [3:0]                              out_matched_rule,
  output logic [15:0]                             out_steps_left
);

  tgs_pkg::state_t state_r, state_nxt;

  logic                            lim_en_r;
  logic [tgs_pkg::LIMIT_W-1:0]     lim_r;
  logic [4:0]                      rule_cnt_r;
  logic [tgs_pkg::STATE_W-1:0]     start_st_r;

  logic [tgs_pkg::POS_W-1:0]       head_row_r, head_row_nxt;
  logic [tgs_pkg::POS_W-1:0]       head_col_r, head_col_nxt;
  tgs_pkg::dir_t                   head_dir_r, head_dir_nxt;
  logic [tgs_pkg::STATE_W-1:0]     head_st_r, head_st_nxt;
  logic [tgs_pkg::LIMIT_W-1:0]     steps_r, steps_nxt;
  logic [tgs_pkg::RULE_IDX_W-1:0]  last_rule_r, last_rule_nxt;

  tgs_pkg::status_t                status_r, status_nxt;
  logic                            scan_pend_r, scan_pend_nxt;
  logic                            cell_sel_r, cell_sel_nxt;
  logic                            cell_oob_r, cell_oob_nxt;
  logic [tgs_pkg::CELL_AW-1:0]     cell_addr_r, cell_addr_nxt;
  logic [tgs_pkg::CELL_AW-1:0]     sweep_r, sweep_nxt;
  logic [tgs_pkg::RULE_CNT_W-1:0]  scan_idx_r, scan_idx_nxt;

  logic                            out_valid_r;
  logic [1:0]                      out_status_r;
  logic [tgs_pkg::POS_W-1:0]       out_row_r, out_col_r;
  logic [1:0]                      out_dir_r;
  logic [3:0]                      out_st_r, out_color_r, out_rule_r;
  logic [15:0]                     out_steps_r;

  logic                            accept;
  logic [tgs_pkg::CELL_AW-1:0]     head_addr;
  logic [tgs_pkg::RULE_CNT_W-1:0]  rule_lim;
  logic                            scan_live;
  logic                            rule_we;
  tgs_pkg::rule_t                  wr_rule, rd_rule;
  logic                            hit;
  tgs_pkg::grid_wr_t               grid_wr;
  logic                            grid_re;
  logic [tgs_pkg::CELL_AW-1:0]     grid_raddr;
  logic [tgs_pkg::COLOR_BITS-1:0]  grid_rdata;
  tgs_pkg::dir_t                   turned_dir;
  logic [tgs_pkg::POS_W-1:0]       mv_row, mv_col;

  assign busy   = (state_r != tgs_pkg::S_IDLE);
  assign accept = start && !busy;

  assign head_addr = tgs_pkg::CELL_AW'(head_row_r) *
                     tgs_pkg::CELL_AW'(tgs_pkg::GRID_SIZE) +
                     tgs_pkg::CELL_AW'(head_col_r);

  assign rule_lim  = (int'(rule_cnt_r) > tgs_pkg::MAX_RULES) ?
                     tgs_pkg::RULE_CNT_W'(tgs_pkg::MAX_RULES) :
                     tgs_pkg::RULE_CNT_W'(rule_cnt_r);
  assign scan_live = (scan_idx_r < rule_lim);

  always_comb begin
    wr_rule.st       = in_rule_state;
    wr_rule.st_any   = in_rule_state_any;
    wr_rule.col      = in_rule_color[tgs_pkg::COLOR_BITS-1:0];
    wr_rule.col_any  = in_rule_color_any;
    wr_rule.ncol     = in_rule_new_color[tgs_pkg::COLOR_BITS-1:0];
    wr_rule.col_keep = in_rule_color_keep;
    wr_rule.turn     = tgs_pkg::turn_t'(in_rule_turn);
    wr_rule.nst      = in_rule_new_state;
    wr_rule.st_keep  = in_rule_state_keep;
  end

  assign rule_we = accept && (in_operation == tgs_pkg::OP_WRITE_RULE) &&
                   (int'(in_rule_index) < tgs_pkg::MAX_RULES);

  tgs_rule_unit u_rules (
    .clk       (clk),
    .wr_en     (rule_we),
    .wr_idx    (tgs_pkg::RULE_IDX_W'(in_rule_index)),
    .wr_rule   (wr_rule),
    .rd_idx    (scan_idx_r[tgs_pkg::RULE_IDX_W-1:0]),
    .cur_state (head_st_r),
    .cur_color (grid_rdata),
    .hit       (hit),
    .rd_rule   (rd_rule)
  );

  always_comb begin
    grid_wr.we   = 1'b0;
    grid_wr.addr = head_addr;
    grid_wr.data = rd_rule.ncol;
    if ((state_r == tgs_pkg::S_INIT) || (state_r == tgs_pkg::S_CLEAR)) begin
      grid_wr.we   = 1'b1;
      grid_wr.addr = sweep_r;
      grid_wr.data = '0;
    end else if (state_r == tgs_pkg::S_SCAN) begin
      grid_wr.we = scan_live && hit && !rd_rule.col_keep;
    end
  end

  assign grid_re    = (state_r == tgs_pkg::S_READ);
  assign grid_raddr = cell_sel_r ? cell_addr_r : head_addr;

  tgs_grid_mem u_grid (
    .clk   (clk),
    .wr    (grid_wr),
    .re    (grid_re),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  always_comb begin
    case (rd_rule.turn)
      tgs_pkg::TURN_LEFT:     turned_dir = tgs_pkg::dir_t'(head_dir_r + 2'd3);
      tgs_pkg::TURN_STRAIGHT: turned_dir = head_dir_r;
      tgs_pkg::TURN_RIGHT:    turned_dir = tgs_pkg::dir_t'(head_dir_r + 2'd1);
      tgs_pkg::TURN_BACK:     turned_dir = tgs_pkg::dir_t'(head_dir_r + 2'd2);
      default:                turned_dir = head_dir_r;
    endcase
  end

  always_comb begin
    mv_row = head_row_r;
    mv_col = head_col_r;
    case (turned_dir)
      tgs_pkg::HD_ROW_DOWN:
        mv_row = (head_row_r == '0) ? tgs_pkg::POS_MAX : head_row_r - 1'b1;
      tgs_pkg::HD_COL_UP:
        mv_col = (head_col_r == tgs_pkg::POS_MAX) ? '0 : head_col_r + 1'b1;
      tgs_pkg::HD_ROW_UP:
        mv_row = (head_row_r == tgs_pkg::POS_MAX) ? '0 : head_row_r + 1'b1;
      tgs_pkg::HD_COL_DOWN:
        mv_col = (head_col_r == '0) ? tgs_pkg::POS_MAX : head_col_r - 1'b1;
      default: begin
        mv_row = head_row_r;
        mv_col = head_col_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tgs_pkg::S_INIT: begin
        if (sweep_r == tgs_pkg::SWEEP_LAST) state_nxt = tgs_pkg::S_IDLE;
      end
      tgs_pkg::S_IDLE: begin
        if (start) begin
          if (in_operation == tgs_pkg::OP_CLEAR) state_nxt = tgs_pkg::S_CLEAR;
          else state_nxt = tgs_pkg::S_READ;
        end
      end
      tgs_pkg::S_CLEAR: begin
        if (sweep_r == tgs_pkg::SWEEP_LAST) state_nxt = tgs_pkg::S_READ;
      end
      tgs_pkg::S_READ: begin
        state_nxt = scan_pend_r ? tgs_pkg::S_SCAN : tgs_pkg::S_DONE;
      end
      tgs_pkg::S_SCAN: begin
        if (!scan_live) state_nxt = tgs_pkg::S_DONE;
        else if (hit) state_nxt = tgs_pkg::S_READ;
      end
      tgs_pkg::S_DONE: begin
        state_nxt = tgs_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tgs_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    head_row_nxt  = head_row_r;
    head_col_nxt  = head_col_r;
    head_dir_nxt  = head_dir_r;
    head_st_nxt   = head_st_r;
    steps_nxt     = steps_r;
    last_rule_nxt = last_rule_r;
    status_nxt    = status_r;
    scan_pend_nxt = scan_pend_r;
    cell_sel_nxt  = cell_sel_r;
    cell_oob_nxt  = cell_oob_r;
    cell_addr_nxt = cell_addr_r;
    sweep_nxt     = sweep_r;
    scan_idx_nxt  = scan_idx_r;
    case (state_r)
      tgs_pkg::S_INIT, tgs_pkg::S_CLEAR: begin
        sweep_nxt = sweep_r + 1'b1;
      end
      tgs_pkg::S_IDLE: begin
        if (start) begin
          cell_sel_nxt  = (in_operation == tgs_pkg::OP_READ_CELL);
          cell_addr_nxt = tgs_pkg::CELL_AW'(in_cell_address);
          cell_oob_nxt  = (in_operation == tgs_pkg::OP_READ_CELL) &&
                          !(int'(in_cell_address) < tgs_pkg::CELLS);
          status_nxt    = tgs_pkg::STAT_DONE;
          scan_pend_nxt = 1'b0;
          scan_idx_nxt  = '0;
          sweep_nxt     = '0;
          case (tgs_pkg::op_t'(in_operation))
            tgs_pkg::OP_STEP: begin
              if (lim_en_r && (steps_r == '0)) begin
                status_nxt = tgs_pkg::STAT_EXHAUSTED;
              end else begin
                scan_pend_nxt = 1'b1;
                if (lim_en_r) steps_nxt = steps_r - 1'b1;
              end
            end
            tgs_pkg::OP_CLEAR: begin
              head_row_nxt = tgs_pkg::POS_CENTER;
              head_col_nxt = tgs_pkg::POS_CENTER;
              head_dir_nxt = tgs_pkg::HD_COL_UP;
              head_st_nxt  = start_st_r;
              steps_nxt    = lim_r;
            end
            default: begin
              scan_pend_nxt = 1'b0;
            end
          endcase
        end
      end
      tgs_pkg::S_READ: begin
        scan_pend_nxt = 1'b0;
      end
      tgs_pkg::S_SCAN: begin
        if (!scan_live) begin
          status_nxt = tgs_pkg::STAT_NO_MATCH;
        end else if (hit) begin
          head_dir_nxt  = turned_dir;
          head_row_nxt  = mv_row;
          head_col_nxt  = mv_col;
          last_rule_nxt = scan_idx_r[tgs_pkg::RULE_IDX_W-1:0];
          if (!rd_rule.st_keep) head_st_nxt = rd_rule.nst;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      default: begin
        sweep_nxt = sweep_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_en_r   <= 1'b0;
      lim_r      <= '0;
      rule_cnt_r <= '0;
      start_st_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tgs_pkg::CFG_LIMIT_EN:    lim_en_r   <= cfg_wdata[0];
        tgs_pkg::CFG_LIMIT:       lim_r      <= cfg_wdata[tgs_pkg::LIMIT_W-1:0];
        tgs_pkg::CFG_RULE_COUNT:  rule_cnt_r <= cfg_wdata[4:0];
        tgs_pkg::CFG_START_STATE: start_st_r <= cfg_wdata[tgs_pkg::STATE_W-1:0];
        default:                  lim_en_r   <= lim_en_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tgs_pkg::S_INIT;
      head_row_r  <= tgs_pkg::POS_CENTER;
      head_col_r  <= tgs_pkg::POS_CENTER;
      head_dir_r  <= tgs_pkg::HD_COL_UP;
      head_st_r   <= '0;
      steps_r     <= '0;
      last_rule_r <= '0;
      status_r    <= tgs_pkg::STAT_DONE;
      scan_pend_r <= 1'b0;
      cell_sel_r  <= 1'b0;
      cell_oob_r  <= 1'b0;
      sweep_r     <= '0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_row_r  <= head_row_nxt;
      head_col_r  <= head_col_nxt;
      head_dir_r  <= head_dir_nxt;
      head_st_r   <= head_st_nxt;
      steps_r     <= steps_nxt;
      last_rule_r <= last_rule_nxt;
      status_r    <= status_nxt;
      scan_pend_r <= scan_pend_nxt;
      cell_sel_r  <= cell_sel_nxt;
      cell_oob_r  <= cell_oob_nxt;
      sweep_r     <= sweep_nxt;
      scan_idx_r  <= scan_idx_nxt;
      out_valid_r <= (state_r == tgs_pkg::S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    cell_addr_r <= cell_addr_nxt;
    if (state_r == tgs_pkg::S_DONE) begin
      out_status_r <= status_r;
      out_row_r    <= head_row_r;
      out_col_r    <= head_col_r;
      out_dir_r    <= head_dir_r;
      out_st_r     <= head_st_r;
      out_color_r  <= cell_oob_r ? 4'd0 : 4'(grid_rdata);
      out_rule_r   <= 4'(last_rule_r);
      out_steps_r  <= steps_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_pos_row       = out_row_r;
  assign out_pos_col       = out_col_r;
  assign out_heading       = out_dir_r;
  assign out_current_state = out_st_r;
  assign out_cell_color    = out_color_r;
  assign out_matched_rule  = out_rule_r;
  assign out_steps_left    = out_steps_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == tgs_pkg::STAT_EXHAUSTED) |-> (out_steps_left == '0))
    else $error("budget exhausted with steps left");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tgs_pkg::S_SCAN) |-> (scan_idx_r <= rule_lim))
    else $error("rule scan ran past the rules in use");

endmodule

`default_nettype wire
